### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, switched off while reset is high.
`define PPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/pps_pkg.sv
// Types and constants shared by the priority scheduler modules.
`default_nettype none
package pps_pkg;

   localparam int PID_W   = 8;
   localparam int TIME_W  = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int OP_W    = 2;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Request operation codes; the fourth code means nothing and is dropped.
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Classified command as carried through the queue.
   typedef struct packed {
      op_type              kind;
      logic [PID_W-1:0]    pid;
      logic [TIME_W-1:0]   arrival;
      logic [BURST_W-1:0]  burst;
      logic [PRIO_W-1:0]   prio;
   } cmd_type;

   // Queue write side (front to queue) and read side (queue to back).
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_port_type;

   // One row of the process table.
   typedef struct packed {
      logic [PID_W-1:0]    pid;
      logic [TIME_W-1:0]   arrival;
      logic [BURST_W-1:0]  remaining;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

endpackage
`default_nettype wire

### rtl/pps_req_if.sv
// Request channel: valid/ready handshake with the process command payload.
`default_nettype none
interface pps_req_if import pps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [PID_W-1:0]   pid;
   logic [TIME_W-1:0]  arrival;
   logic [BURST_W-1:0] burst;
   logic [PRIO_W-1:0]  prio_level;

   modport source (output valid, op, pid, arrival, burst, prio_level, input ready);
   modport sink   (input valid, op, pid, arrival, burst, prio_level, output ready);
endinterface
`default_nettype wire

### rtl/pps_rsp_if.sv
// Response channel: valid/ready handshake with the tick report payload.
`default_nettype none
interface pps_rsp_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] slot_time;
   logic [PID_W-1:0]  run_pid;
   logic              idle;
   logic              finished;
   logic              all_done;

   modport source (output valid, slot_time, run_pid, idle, finished, all_done, input ready);
   modport sink   (input valid, slot_time, run_pid, idle, finished, all_done, output ready);
endinterface
`default_nettype wire

### rtl/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/pps_queue.sv
// Short command queue between the front and back parts.
`default_nettype none
module pps_queue import pps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_port_type wr,
   output      logic       full,
   output      q_port_type rd,
   input  wire logic       pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push_ok = wr.valid && !full;
   assign pop_ok  = pop && (count_ff != '0);

   assign rd.valid = (count_ff != '0);
   assign rd.cmd   = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slots_ff[wr_ptr_ff] <= wr.cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/pps_front.sv
// Front part: takes requests, decodes the op and queues valid commands.
`default_nettype none
module pps_front import pps_pkg::*; (
   pps_req_if.sink         req_chan,
   input  wire logic       q_full,
   output      q_port_type q_wr
);

   logic accept;

   // Ready only while the queue has room
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   // Classify the request; the unused op code is dropped here
   always_comb begin
      q_wr.valid       = 1'b0;
      q_wr.cmd.kind    = OP_TICK;
      q_wr.cmd.pid     = req_chan.pid;
      q_wr.cmd.arrival = req_chan.arrival;
      q_wr.cmd.burst   = req_chan.burst;
      q_wr.cmd.prio    = req_chan.prio_level;
      unique case (req_chan.op)
         OP_LOAD: begin
            q_wr.valid    = accept;
            q_wr.cmd.kind = OP_LOAD;
         end
         OP_TICK: begin
            q_wr.valid    = accept;
            q_wr.cmd.kind = OP_TICK;
         end
         OP_CLEAR: begin
            q_wr.valid    = accept;
            q_wr.cmd.kind = OP_CLEAR;
         end
         default: begin
            q_wr.valid = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/pps_back.sv
// Back part: executes loads, clears and ticks against the process table.
`default_nettype none
module pps_back import pps_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_port_type q_rd,
   output      logic       q_pop,
   pps_rsp_if.source       rsp_chan
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int ROW_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   entry_type          best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [CNT_W-1:0]   done_ff, done_in;
   logic [TIME_W-1:0]  now_ff, now_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [PID_W-1:0]   rsp_pid_ff, rsp_pid_in;
   logic               rsp_idle_ff, rsp_idle_in;
   logic               rsp_fin_ff, rsp_fin_in;
   logic               rsp_all_ff, rsp_all_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic [ROW_W-1:0]   rd_data;
   entry_type          rd_entry;

   logic               live;
   logic               better;
   logic               table_full;
   logic               out_free;
   logic [BURST_W-1:0] dec_rem;
   logic               fin;
   logic [CNT_W-1:0]   done_next;

   // Process table
   pps_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ROW_W'(wr_entry)),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);

   // Slot that came back from the table: loaded, has work, has arrived
   assign live   = (CNT_W'(cmp_idx_ff) < loaded_ff) && (rd_entry.remaining != '0)
                   && (rd_entry.arrival <= now_ff);
   assign better = (rd_entry.prio < best_ff.prio)
                   || ((rd_entry.prio == best_ff.prio) && (rd_entry.arrival < best_ff.arrival));

   assign table_full = (loaded_ff == CNT_W'(MAX_PROCS));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign dec_rem    = best_ff.remaining - 1'b1;
   assign fin        = found_ff && (dec_rem == '0);
   assign done_next  = done_ff + CNT_W'(fin);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      loaded_in    = loaded_ff;
      done_in      = done_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_time_in  = rsp_time_ff;
      rsp_pid_in   = rsp_pid_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_all_in   = rsp_all_ff;
      wr_en        = 1'b0;
      wr_addr      = best_idx_ff;
      wr_entry     = best_ff;
      q_pop        = 1'b0;

      // Running minimum over the scanned slots; strict compare keeps the lower slot
      if (cmp_vld_ff && live && (!found_ff || better)) begin
         found_in    = 1'b1;
         best_in     = rd_entry;
         best_idx_in = cmp_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd.valid) begin
               q_pop = 1'b1;
               case (q_rd.cmd.kind)
                  OP_LOAD: begin
                     if (!table_full) begin
                        wr_en              = 1'b1;
                        wr_addr            = loaded_ff[IDX_W-1:0];
                        wr_entry.pid       = q_rd.cmd.pid;
                        wr_entry.arrival   = q_rd.cmd.arrival;
                        wr_entry.remaining = q_rd.cmd.burst;
                        wr_entry.prio      = q_rd.cmd.prio;
                        loaded_in          = loaded_ff + 1'b1;
                        if (q_rd.cmd.burst == '0) begin
                           done_in = done_ff + 1'b1;
                        end
                     end
                  end
                  OP_TICK: begin
                     cnt_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     loaded_in = '0;
                     done_in   = '0;
                     now_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One table read per cycle; the read data is compared in the cycle after the read
            cmp_vld_in = 1'b1;
            cmp_idx_in = cnt_ff;
            if (cnt_ff == IDX_W'(MAX_PROCS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               if (found_ff) begin
                  wr_en              = 1'b1;
                  wr_addr            = best_idx_ff;
                  wr_entry.remaining = dec_rem;
               end
               done_in      = done_next;
               rsp_valid_in = 1'b1;
               rsp_time_in  = now_ff;
               rsp_pid_in   = found_ff ? best_ff.pid : '0;
               rsp_idle_in  = !found_ff;
               rsp_fin_in   = fin;
               rsp_all_in   = (done_next == loaded_ff);
               if (now_ff != '1) begin
                  now_in = now_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         loaded_ff    <= '0;
         done_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         loaded_ff    <= loaded_in;
         done_ff      <= done_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_time_ff <= rsp_time_in;
      rsp_pid_ff  <= rsp_pid_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_all_ff  <= rsp_all_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.slot_time = rsp_time_ff;
   assign rsp_chan.run_pid   = rsp_pid_ff;
   assign rsp_chan.idle      = rsp_idle_ff;
   assign rsp_chan.finished  = rsp_fin_ff;
   assign rsp_chan.all_done  = rsp_all_ff;

endmodule
`default_nettype wire

### rtl/preemptive_priority_scheduler.sv
// Tick request: queued, popped by the back end, scanned over every table slot, then the response
// is registered once the output is free; load and clear requests give no response.
// The back end handles one tick at a time, its slot scan limited by the table's
// single read port; loads and clears run in the idle state, behind a two-deep queue.
// Reset (synchronous) empties the queue and clears time, fill and done counts; table rows
// are not swept, the fill count marks which rows hold processes.
`default_nettype none
module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   pps_req_if.sink   req_chan,
   pps_rsp_if.source rsp_chan
);

   q_port_type q_wr;
   q_port_type q_rd;
   logic       q_full;
   logic       q_pop;

   // Request decode
   pps_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_wr     (q_wr)
   );

   // Command queue
   pps_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .rd    (q_rd),
      .pop   (q_pop)
   );

   // Table and tick execution
   pps_back #(
      .MAX_PROCS (MAX_PROCS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

### rtl/pps_checker.sv
// Port-level checks on the scheduler's response channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pps_checker import pps_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [TIME_W-1:0] rsp_slot_time,
   input wire logic [PID_W-1:0]  rsp_run_pid,
   input wire logic              rsp_idle,
   input wire logic              rsp_finished,
   input wire logic              rsp_all_done
);

   // A stalled response keeps its contents
   `PPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_slot_time, rsp_run_pid, rsp_idle, rsp_finished, rsp_all_done}), "response changed while stalled")

   // No response pending in the cycle after reset
   `PPS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid after reset")

   // An idle tick serves nobody
   `PPS_ASSERT(a_idle_report, rsp_valid && rsp_idle |-> rsp_run_pid == '0 && !rsp_finished, "idle tick reports a pid or completion")

   // A served process that still has work cannot leave the table all done
   `PPS_ASSERT(a_done_count, rsp_valid && !rsp_idle && !rsp_finished |-> !rsp_all_done, "all done while served process has work left")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_slot_time (rsp_chan.slot_time),
   .rsp_run_pid   (rsp_chan.run_pid),
   .rsp_idle      (rsp_chan.idle),
   .rsp_finished  (rsp_chan.finished),
   .rsp_all_done  (rsp_chan.all_done)
);
`default_nettype wire

### tb/sv/preemptive_priority_scheduler_tb.sv
// Self-checking testbench for the preemptive priority scheduler: driver, sink and scoreboard.
`default_nettype none
module preemptive_priority_scheduler_tb;
   import pps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int MAX_PRINTED = 50;
   // fourth op code: the block drops it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one request as queued for the driver
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [PID_W-1:0]   pid;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      bit                 drain;   // wait for all tick reports before sending
      bit                 quiet;   // no stalls on either side around this request
   } sched_request;

   // expected report of one tick
   typedef struct {
      logic [TIME_W-1:0] slot_time;
      logic [PID_W-1:0]  run_pid;
      logic              idle;
      logic              finished;
      logic              all_done;
   } tick_report;

   logic clock;
   logic reset;

   pps_req_if req_bus ();
   pps_rsp_if rsp_bus ();

   preemptive_priority_scheduler #(.MAX_PROCS(NPROC)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   sched_request request_backlog[$];
   tick_report   expected_ticks[$];
   sched_request on_bus;
   bit           hold_next;
   bit           quiet_mode;
   logic         calm;
   int           n_items;
   int           n_mismatch;
   int           n_reports;
   int           send_gap;
   int           take_gap;
   longint       cycle_count;

   // shadow copy of the process table
   bit                 tbl_used [NPROC];
   logic [PID_W-1:0]   tbl_pid  [NPROC];
   logic [TIME_W-1:0]  tbl_arr  [NPROC];
   logic [BURST_W-1:0] tbl_left [NPROC];
   logic [PRIO_W-1:0]  tbl_prio [NPROC];
   logic [TIME_W-1:0]  sched_now;
   int                 n_loaded;
   int                 n_done;

   function automatic void clear_table();
      for (int i = 0; i < NPROC; i++) begin
         tbl_used[i] = 1'b0;
         tbl_pid[i]  = '0;
         tbl_arr[i]  = '0;
         tbl_left[i] = '0;
         tbl_prio[i] = '0;
      end
      sched_now = '0;
      n_loaded  = 0;
      n_done    = 0;
   endfunction

   // apply one accepted request to the shadow table; ticks yield a report
   function automatic void update_schedule(sched_request r);
      int         pick;
      tick_report rep;
      case (r.op)
         OP_LOAD: begin
            if (n_loaded < NPROC) begin
               tbl_used[n_loaded] = 1'b1;
               tbl_pid[n_loaded]  = r.pid;
               tbl_arr[n_loaded]  = r.arrival;
               tbl_left[n_loaded] = r.burst;
               tbl_prio[n_loaded] = r.prio;
               if (r.burst == 0) n_done++;
               n_loaded++;
            end
         end
         OP_TICK: begin
            pick = -1;
            // best ready process: lowest prio, then earliest arrival, then lowest slot
            for (int i = 0; i < NPROC; i++) begin
               if (tbl_used[i] && tbl_left[i] != 0 && tbl_arr[i] <= sched_now) begin
                  if (pick < 0 || tbl_prio[i] < tbl_prio[pick] ||
                      (tbl_prio[i] == tbl_prio[pick] && tbl_arr[i] < tbl_arr[pick]))
                     pick = i;
               end
            end
            rep.slot_time = sched_now;
            rep.run_pid   = '0;
            rep.idle      = 1'b1;
            rep.finished  = 1'b0;
            if (pick >= 0) begin
               rep.idle    = 1'b0;
               rep.run_pid = tbl_pid[pick];
               tbl_left[pick] = tbl_left[pick] - 1'b1;
               if (tbl_left[pick] == 0) begin
                  rep.finished = 1'b1;
                  n_done++;
               end
            end
            rep.all_done = (n_done == n_loaded);
            // time saturates at its maximum
            if (sched_now != '1) sched_now = sched_now + 1'b1;
            expected_ticks.push_back(rep);
         end
         OP_CLEAR: clear_table();
         default: ;
      endcase
   endfunction

   function automatic void queue_request(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                         logic [TIME_W-1:0] arrival,
                                         logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio);
      sched_request r;
      r.op      = op;
      r.pid     = pid;
      r.arrival = arrival;
      r.burst   = burst;
      r.prio    = prio;
      r.drain   = hold_next;
      r.quiet   = quiet_mode;
      hold_next = 1'b0;
      if (op != OP_UNUSED) n_items++;
      request_backlog.push_back(r);
   endfunction

   task automatic report_mismatch(string what);
      if (n_mismatch < MAX_PRINTED)
         $display("%0t ns check failed, tick report %0d: %s", $time, n_reports, what);
      n_mismatch++;
   endtask

   // clock, reset and known input levels from time zero
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      calm               = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.op         = '0;
      req_bus.pid        = '0;
      req_bus.arrival    = '0;
      req_bus.burst      = '0;
      req_bus.prio_level = '0;
      rsp_bus.ready      = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver: pops the backlog, random gaps, optional drain hold
   always @(posedge clock) begin : request_driver
      bit launch;
      launch = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            update_schedule(on_bus);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].drain && expected_ticks.size() != 0)) begin
               if (!request_backlog[0].quiet && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(0, 15);
               else
                  launch = 1'b1;
            end
            if (launch) begin
               on_bus = request_backlog.pop_front();
               req_bus.op         <= on_bus.op;
               req_bus.pid        <= on_bus.pid;
               req_bus.arrival    <= on_bus.arrival;
               req_bus.burst      <= on_bus.burst;
               req_bus.prio_level <= on_bus.prio;
               calm               <= on_bus.quiet;
            end
            req_bus.valid <= launch;
         end
      end
   end

   // response sink with random stall bursts
   always @(posedge clock) begin : response_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         take_gap = $urandom_range(0, 15);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each accepted tick report against the oldest expectation
   always @(posedge clock) begin : report_monitor
      tick_report want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_ticks.size() == 0) begin
            report_mismatch("report with no tick outstanding");
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_bus.slot_time !== want.slot_time)
               report_mismatch($sformatf("slot_time %h, want %h",
                                         rsp_bus.slot_time, want.slot_time));
            if (rsp_bus.run_pid !== want.run_pid)
               report_mismatch($sformatf("run_pid %h, want %h", rsp_bus.run_pid, want.run_pid));
            if (rsp_bus.idle !== want.idle)
               report_mismatch($sformatf("idle %b, want %b", rsp_bus.idle, want.idle));
            if (rsp_bus.finished !== want.finished)
               report_mismatch($sformatf("finished %b, want %b",
                                         rsp_bus.finished, want.finished));
            if (rsp_bus.all_done !== want.all_done)
               report_mismatch($sformatf("all_done %b, want %b",
                                         rsp_bus.all_done, want.all_done));
         end
         n_reports++;
      end
   end

   // hang guard
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      int nproc;
      int nticks;
      int pick;
      logic [TIME_W-1:0]  arr;
      logic [BURST_W-1:0] bst;
      logic [PRIO_W-1:0]  pri;

      clear_table();
      hold_next  = 1'b0;
      quiet_mode = 1'b0;

      // directed: empty table, zero burst, field extremes, ties, dropped op, full table
      queue_request(OP_TICK, '0, '0, '0, '0);
      queue_request(OP_LOAD, 8'h00, 16'h0000, 16'h0000, 8'h00);
      queue_request(OP_TICK, '1, '1, '1, '1);
      queue_request(OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      queue_request(OP_LOAD, 8'hA5, 16'h0001, 16'h0002, 8'h07);
      queue_request(OP_LOAD, 8'h5A, 16'h0000, 16'h0001, 8'h07);
      queue_request(OP_LOAD, 8'h11, 16'h0000, 16'h0001, 8'h07);
      queue_request(OP_UNUSED, 8'h3C, 16'h1234, 16'h0001, 8'h00);
      repeat (5) queue_request(OP_TICK, 8'h5A, 16'hA5A5, 16'h5A5A, 8'hA5);
      for (int i = 0; i < 11; i++)
         queue_request(OP_LOAD, 8'(8'h20 + i), 16'h0000, 16'h0001, 8'd200);
      // table is full here: this one must be dropped although it would win
      queue_request(OP_LOAD, 8'hEE, 16'h0000, 16'h0001, 8'h00);
      queue_request(OP_TICK, '0, '0, '0, '0);

      // random: mostly clear / load burst / tick run sequences
      while (n_items < RANDOM_ITEMS) begin
         quiet_mode = ($urandom_range(0, 3) == 0);
         hold_next  = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 7) != 0)
            queue_request(OP_CLEAR, PID_W'($urandom), TIME_W'($urandom),
                          BURST_W'($urandom), PRIO_W'($urandom));
         nproc = $urandom_range(1, 17);
         for (int k = 0; k < nproc; k++) begin
            arr  = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                               : TIME_W'($urandom_range(0, 24));
            pick = $urandom_range(0, 9);
            bst  = (pick == 0) ? 16'h0000 :
                   (pick == 1) ? BURST_W'($urandom_range(1, 65535))
                               : BURST_W'($urandom_range(1, 6));
            pri  = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 255))
                                               : PRIO_W'($urandom_range(0, 3));
            queue_request(OP_LOAD, PID_W'($urandom), arr, bst, pri);
         end
         nticks = $urandom_range(4, 40);
         for (int t = 0; t < nticks; t++) begin
            // late arrivals that may preempt the running process
            if ($urandom_range(0, 11) == 0)
               queue_request(OP_LOAD, PID_W'($urandom), TIME_W'(t + $urandom_range(0, 5)),
                             BURST_W'($urandom_range(1, 4)), PRIO_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 24) == 0)
               queue_request(OP_UNUSED, PID_W'($urandom), TIME_W'($urandom),
                             BURST_W'($urandom), PRIO_W'($urandom));
            queue_request(OP_TICK, PID_W'($urandom), TIME_W'($urandom),
                          BURST_W'($urandom), PRIO_W'($urandom));
         end
      end

      // closing phase without stalls: later, more urgent arrivals preempt a long job
      quiet_mode = 1'b1;
      hold_next  = 1'b1;
      queue_request(OP_CLEAR, '0, '0, '0, '0);
      queue_request(OP_LOAD, 8'h3C, 16'h0000, 16'h0006, 8'd200);
      queue_request(OP_LOAD, 8'hC3, 16'h0002, 16'h0002, 8'd10);
      queue_request(OP_LOAD, 8'h77, 16'h0004, 16'h0003, 8'd5);
      queue_request(OP_LOAD, 8'h88, 16'h0004, 16'h0001, 8'd5);
      repeat (16) queue_request(OP_TICK, '0, '0, '0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (3 * (NPROC + 3)) @(posedge clock);

      if (n_mismatch == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
